[hw/rtl/bhpq_pkg.sv]
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Sizes, operation codes, sequencer states and the heap order compare.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   typedef logic [KEY_WIDTH-1:0] key_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [ADDR_W-1:0]    addr_type;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_UP_RD   = 6'b000010,
      ST_UP_CMP  = 6'b000100,
      ST_RM_RD   = 6'b001000,
      ST_DN_RD   = 6'b010000,
      ST_DN_CMP  = 6'b100000
   } state_type;

   localparam logic ORDER_MAX = 1'b0;

   // True when key a belongs above key b in the heap (ties count).
   function automatic logic ranks_above(input logic order, input key_type a,
                                        input key_type b);
      logic res;
      if (order == ORDER_MAX) begin
         res = (a >= b);
      end else begin
         res = (a <= b);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/binary_heap_priority_queue.sv]
// Clear, no-op, refused insert and empty remove finish straight from idle. Insert
// climbs one level per read and compare, until a parent stops it or the root is
// reached; remove ends at the root read for the last key, else sinks the last key
// level by level until the children stop it or it reaches a leaf. One item at a
// time: busy stays high until the sequencer ends. The receiver cannot stall: rsp_valid
// is one cycle wide. Synchronous reset empties the heap and selects max-heap order.
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Array heap with 1-based positions, sifted one level per read and compare state
// pair through a two-read, one-write key memory.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue
   import bhpq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // command channel
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_func,
   input  wire logic [KEY_WIDTH-1:0] req_key_in,
   // result channel
   output logic                      rsp_valid,
   output logic [KEY_WIDTH-1:0]      rsp_removed_key,
   output logic [KEY_WIDTH-1:0]      rsp_top_key,
   output logic [CNT_W-1:0]          rsp_entry_count,
   output logic                      rsp_full_error,
   output logic                      rsp_empty_error,
   // configuration write channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 csr_order_mode
);

   // -------------------------------------------------------------------------
   // State
   // -------------------------------------------------------------------------
   state_type state_ff, state_in;
   cnt_type   cnt_ff, cnt_in;      // keys held
   cnt_type   pos_ff, pos_in;      // current hole position, 1-based
   key_type   key_ff, key_in;      // key being sifted
   key_type   removed_ff, removed_in;
   key_type   top_ff, top_in;      // mirror of position 1
   logic      order_ff;

   // key memory: position p lives at address p-1
   key_type   heap_mem [CAPACITY];
   logic      wr_en;
   addr_type  wr_addr;
   key_type   wr_data;
   addr_type  rd_addr0, rd_addr1;
   key_type   rd0_ff, rd1_ff;

   // result registers
   logic      rsp_valid_ff;
   key_type   rsp_removed_ff, rsp_top_ff;
   cnt_type   rsp_cnt_ff;
   logic      rsp_full_ff, rsp_empty_ff;

   logic      fin;
   key_type   fin_removed;
   logic      fin_full, fin_empty;

   logic              accept;
   func_type          func;
   logic [CNT_W:0]    left_pos;    // 2*pos, one bit wider than the count
   logic [CNT_W:0]    right_pos;
   logic [CNT_W:0]    cnt_ext;
   cnt_type           parent_pos;
   logic              pick_left, pick_right;
   key_type           pick_key;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign func      = func_type'(req_func);
   assign csr_ready = 1'b1;

   assign left_pos   = {pos_ff, 1'b0};
   assign right_pos  = {pos_ff, 1'b1};
   assign cnt_ext    = {1'b0, cnt_ff};
   assign parent_pos = pos_ff >> 1;

   // Child pick for sift down: left beats the key if it ranks above it, then
   // right beats whatever won so far. Right only counts when it is in range.
   assign pick_left  = ranks_above(order_ff, rd0_ff, key_ff);
   assign pick_key   = pick_left ? rd0_ff : key_ff;
   assign pick_right = (right_pos <= cnt_ext) && ranks_above(order_ff, rd1_ff, pick_key);

   // -------------------------------------------------------------------------
   // Sequencer
   // -------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      key_in      = key_ff;
      removed_in  = removed_ff;
      wr_en       = 1'b0;
      wr_addr     = addr_type'(pos_ff - cnt_type'(1));
      wr_data     = key_ff;
      rd_addr0    = '0;
      rd_addr1    = '0;
      fin         = 1'b0;
      fin_removed = '0;
      fin_full    = 1'b0;
      fin_empty   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (func)
                  FUNC_INSERT: begin
                     if (cnt_ff == cnt_type'(CAPACITY)) begin
                        // drop the key, flag full
                        fin      = 1'b1;
                        fin_full = 1'b1;
                     end else begin
                        cnt_in   = cnt_ff + cnt_type'(1);
                        pos_in   = cnt_ff + cnt_type'(1);
                        key_in   = req_key_in;
                        state_in = ST_UP_RD;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (cnt_ff == '0) begin
                        fin       = 1'b1;
                        fin_empty = 1'b1;
                     end else begin
                        // fetch the root and the last entry together
                        rd_addr0 = '0;
                        rd_addr1 = addr_type'(cnt_ff - cnt_type'(1));
                        state_in = ST_RM_RD;
                     end
                  end
                  FUNC_CLEAR: begin
                     cnt_in = '0;
                     fin    = 1'b1;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end

         ST_UP_RD: begin
            if (pos_ff == cnt_type'(1)) begin
               // reached the root: park the key
               wr_en    = 1'b1;
               fin      = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rd_addr0 = addr_type'(parent_pos - cnt_type'(1));
               state_in = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (ranks_above(order_ff, key_ff, rd0_ff)) begin
               // pull the parent down into the hole, climb one level
               wr_data  = rd0_ff;
               pos_in   = parent_pos;
               state_in = ST_UP_RD;
            end else begin
               fin      = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_RM_RD: begin
            removed_in = rd0_ff;
            key_in     = rd1_ff;
            cnt_in     = cnt_ff - cnt_type'(1);
            pos_in     = cnt_type'(1);
            if (cnt_ff == cnt_type'(1)) begin
               fin         = 1'b1;
               fin_removed = rd0_ff;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_DN_RD;
            end
         end

         ST_DN_RD: begin
            if (left_pos > cnt_ext) begin
               // leaf: park the key
               wr_en       = 1'b1;
               fin         = 1'b1;
               fin_removed = removed_ff;
               state_in    = ST_IDLE;
            end else begin
               rd_addr0 = addr_type'(left_pos - (CNT_W+1)'(1));
               rd_addr1 = addr_type'(right_pos - (CNT_W+1)'(1));
               state_in = ST_DN_CMP;
            end
         end

         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (pick_right) begin
               wr_data  = rd1_ff;
               pos_in   = right_pos[CNT_W-1:0];
               state_in = ST_DN_RD;
            end else if (pick_left) begin
               wr_data  = rd0_ff;
               pos_in   = left_pos[CNT_W-1:0];
               state_in = ST_DN_RD;
            end else begin
               fin         = 1'b1;
               fin_removed = removed_ff;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // keep a copy of the root so the result needs no extra read
      top_in = (wr_en && (wr_addr == '0)) ? wr_data : top_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         order_ff <= ORDER_MAX;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_valid && csr_ready) begin
            order_ff <= csr_order_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      key_ff     <= key_in;
      removed_ff <= removed_in;
      top_ff     <= top_in;
   end

   // -------------------------------------------------------------------------
   // Key memory: one write, two registered reads
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd0_ff <= heap_mem[rd_addr0];
      rd1_ff <= heap_mem[rd_addr1];
   end

   // -------------------------------------------------------------------------
   // Result: one strobed item per command
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_removed_ff <= fin_removed;
         rsp_top_ff     <= (cnt_in != '0) ? top_in : '0;
         rsp_cnt_ff     <= cnt_in;
         rsp_full_ff    <= fin_full;
         rsp_empty_ff   <= fin_empty;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_removed_key = rsp_removed_ff;
   assign rsp_top_key     = rsp_top_ff;
   assign rsp_entry_count = rsp_cnt_ff;
   assign rsp_full_error  = rsp_full_ff;
   assign rsp_empty_error = rsp_empty_ff;

endmodule

`default_nettype wire

[tb/binary_heap_priority_queue_test.sv]
// ----------------------------------------------------------------------------
// Binary heap priority queue testbench
// Drives insert, remove, clear and no-op commands through the start/busy
// handshake, with order changes written between phases, and checks every
// result strobe against a cycle-free heap model kept alongside the block.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_test;
   import bhpq_pkg::*;

   // Wait out a quiet stretch longer than the longest sift before touching the order.
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1950;

   // One queued stimulus entry: either a command item or an order write.
   typedef struct {
      logic     is_cfg;
      func_type func;
      key_type  key;
      logic     mode;
   } pending_item_type;

   // What the block must report for one command item.
   typedef struct {
      key_type removed;
      key_type top;
      cnt_type count;
      logic    full;
      logic    empty;
   } heap_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [1:0]           req_func = FUNC_NOP;
   logic [KEY_WIDTH-1:0] req_key_in = '0;
   logic                 rsp_valid;
   logic [KEY_WIDTH-1:0] rsp_removed_key;
   logic [KEY_WIDTH-1:0] rsp_top_key;
   logic [CNT_W-1:0]     rsp_entry_count;
   logic                 rsp_full_error;
   logic                 rsp_empty_error;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic                 csr_order_mode = 1'b0;

   pending_item_type pending_items[$];
   heap_result_type  expected_results[$];

   // Heap model state.
   key_type heap_keys [1:CAPACITY];
   int      heap_count;
   logic    heap_order;

   int error_count   = 0;
   int cycle_count   = 0;
   int items_taken   = 0;
   int results_seen  = 0;
   int inserts_done  = 0;
   int removes_done  = 0;
   int full_refusals = 0;
   int empty_removes = 0;
   int clears_done   = 0;
   int order_writes  = 0;
   int quiet_cycles  = 0;

   binary_heap_priority_queue dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_key_in      (req_key_in),
      .rsp_valid       (rsp_valid),
      .rsp_removed_key (rsp_removed_key),
      .rsp_top_key     (rsp_top_key),
      .rsp_entry_count (rsp_entry_count),
      .rsp_full_error  (rsp_full_error),
      .rsp_empty_error (rsp_empty_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_order_mode  (csr_order_mode)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Heap model
   // ---------------------------------------------------------------------

   // Ties rank above too, so equal keys still move.
   function automatic logic belongs_above(input key_type a, input key_type b);
      if (heap_order == ORDER_MAX) begin
         return a >= b;
      end
      return a <= b;
   endfunction

   task automatic exchange_slots(input int a, input int b);
      key_type hold;
      hold         = heap_keys[a];
      heap_keys[a] = heap_keys[b];
      heap_keys[b] = hold;
   endtask

   // Apply one accepted command to the model and queue what it must report.
   task automatic apply_heap_command(input func_type func, input key_type key);
      heap_result_type res;
      int              pos;
      int              pick;
      int              kid;
      logic            settled;
      res = '{removed: '0, top: '0, count: '0, full: 1'b0, empty: 1'b0};
      case (func)
         FUNC_INSERT: begin
            if (heap_count < CAPACITY) begin
               heap_count++;
               heap_keys[heap_count] = key;
               pos = heap_count;
               // climb while the new key ranks above its parent
               while (pos >= 2 && belongs_above(heap_keys[pos], heap_keys[pos / 2])) begin
                  exchange_slots(pos, pos / 2);
                  pos = pos / 2;
               end
               inserts_done++;
            end else begin
               res.full = 1'b1;
               full_refusals++;
            end
         end
         FUNC_REMOVE: begin
            if (heap_count > 0) begin
               exchange_slots(1, heap_count);
               res.removed = heap_keys[heap_count];
               heap_count--;
               pos     = 1;
               settled = 1'b0;
               // sink the new root toward the better-ranked child
               while (!settled) begin
                  pick = pos;
                  kid  = 2 * pos;
                  if (kid <= heap_count && belongs_above(heap_keys[kid], heap_keys[pick])) begin
                     pick = kid;
                  end
                  if (kid + 1 <= heap_count &&
                      belongs_above(heap_keys[kid + 1], heap_keys[pick])) begin
                     pick = kid + 1;
                  end
                  if (pick == pos) begin
                     settled = 1'b1;
                  end else begin
                     exchange_slots(pos, pick);
                     pos = pick;
                  end
               end
               removes_done++;
            end else begin
               res.empty = 1'b1;
               empty_removes++;
            end
         end
         FUNC_CLEAR: begin
            heap_count = 0;
            clears_done++;
         end
         default: begin
         end
      endcase
      res.top   = (heap_count > 0) ? heap_keys[1] : '0;
      res.count = cnt_type'(heap_count);
      expected_results.push_back(res);
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0d] mismatch: %s", cycle_count, what);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic queue_command(input func_type func, input key_type key);
      pending_items.push_back('{is_cfg: 1'b0, func: func, key: key, mode: 1'b0});
   endtask

   task automatic queue_order(input logic mode);
      pending_items.push_back('{is_cfg: 1'b1, func: FUNC_NOP, key: '0, mode: mode});
   endtask

   // Mix extremes and a narrow range, so ties show up often.
   function automatic key_type pick_key();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) begin
         return '0;
      end else if (roll == 1) begin
         return '1;
      end else if (roll <= 4) begin
         return key_type'($urandom_range(7));
      end
      return key_type'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: feed commands and order writes from the pending queue
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      logic             next_start;
      logic             next_csr;
      logic             calm;
      pending_item_type head;
      if (reset) begin
         start          <= 1'b0;
         req_func       <= FUNC_NOP;
         req_key_in     <= '0;
         csr_valid      <= 1'b0;
         csr_order_mode <= 1'b0;
         heap_count      = 0;
         heap_order      = ORDER_MAX;
         quiet_cycles    = 0;
      end else begin
         next_start = start;
         next_csr   = csr_valid;
         // accept: the item leaves the queue and enters the model
         if (start && !busy) begin
            apply_heap_command(func_type'(req_func), req_key_in);
            void'(pending_items.pop_front());
            items_taken++;
            next_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            heap_order = csr_order_mode;
            order_writes++;
            void'(pending_items.pop_front());
            next_csr = 1'b0;
         end
         // count idle cycles so an order write never lands mid-sift
         if (expected_results.size() == 0 && !busy && !start) begin
            quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end
         // hold off idling through one long stretch of the run
         calm = (items_taken >= 900 && items_taken < 1200);
         if (!next_start && !next_csr && pending_items.size() != 0) begin
            head = pending_items[0];
            if (head.is_cfg) begin
               if (quiet_cycles >= SETTLE_CYCLES) begin
                  next_csr = 1'b1;
                  csr_order_mode <= head.mode;
               end
            end else if (calm || $urandom_range(99) >= 36) begin
               next_start = 1'b1;
               req_func   <= head.func;
               req_key_in <= head.key;
            end
         end
         start     <= next_start;
         csr_valid <= next_csr;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each result strobe with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      heap_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result strobe with no item outstanding");
         end else begin
            want = expected_results.pop_front();
            results_seen++;
            if (rsp_removed_key !== want.removed) begin
               report_mismatch($sformatf("removed_key got %h want %h",
                                         rsp_removed_key, want.removed));
            end
            if (rsp_top_key !== want.top) begin
               report_mismatch($sformatf("top_key got %h want %h", rsp_top_key, want.top));
            end
            if (rsp_entry_count !== want.count) begin
               report_mismatch($sformatf("entry_count got %0d want %0d",
                                         rsp_entry_count, want.count));
            end
            if (rsp_full_error !== want.full) begin
               report_mismatch($sformatf("full_error got %b want %b",
                                         rsp_full_error, want.full));
            end
            if (rsp_empty_error !== want.empty) begin
               report_mismatch($sformatf("empty_error got %b want %b",
                                         rsp_empty_error, want.empty));
            end
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int       made;
      int       phase;
      int       burst;
      int       len;
      int       j;
      int       roll;
      func_type func;

      // directed: empty remove, ties, extremes, no-op, clear, order swap with keys held
      queue_order(ORDER_MAX);
      queue_command(FUNC_REMOVE, 32'hA5A5_5A5A);
      queue_command(FUNC_INSERT, 32'd5);
      queue_command(FUNC_INSERT, 32'd5);
      queue_command(FUNC_INSERT, 32'h0000_0000);
      queue_command(FUNC_INSERT, 32'hFFFF_FFFF);
      queue_command(FUNC_NOP,    32'hFFFF_FFFF);
      queue_command(FUNC_INSERT, 32'd7);
      queue_command(FUNC_REMOVE, 32'h0);
      queue_command(FUNC_REMOVE, 32'h0);
      queue_command(FUNC_CLEAR,  32'h1234_5678);
      queue_command(FUNC_REMOVE, 32'h0);
      queue_command(FUNC_NOP,    32'h0);
      queue_command(FUNC_INSERT, 32'd1);
      queue_command(FUNC_INSERT, 32'd2);
      queue_command(FUNC_INSERT, 32'd3);
      queue_order(~ORDER_MAX);
      queue_command(FUNC_INSERT, 32'h0000_0000);
      queue_command(FUNC_REMOVE, 32'h0);
      queue_command(FUNC_REMOVE, 32'h0);
      queue_command(FUNC_INSERT, 32'hFFFF_FFFF);
      queue_command(FUNC_REMOVE, 32'h0);
      queue_command(FUNC_REMOVE, 32'h0);
      queue_command(FUNC_REMOVE, 32'h0);
      queue_command(FUNC_REMOVE, 32'h0);
      queue_command(FUNC_CLEAR,  32'h0);

      // random: bursts that fill to the brim, drain past empty, or mix
      made  = 0;
      phase = 0;
      while (made < RANDOM_ITEMS) begin
         if (made >= phase * 240) begin
            // alternate orders, now and then repeat the current one
            if ($urandom_range(4) == 0) begin
               queue_order(logic'($urandom_range(1)));
            end else begin
               queue_order(logic'(phase % 2));
            end
            phase++;
         end
         burst = $urandom_range(9);
         len   = $urandom_range(10, 80);
         for (j = 0; j < len; j++) begin
            roll = $urandom_range(99);
            if (burst <= 3) begin
               func = (roll < 85) ? FUNC_INSERT : FUNC_REMOVE;
            end else if (burst <= 6) begin
               func = (roll < 85) ? FUNC_REMOVE : FUNC_INSERT;
            end else if (burst <= 8) begin
               func = (roll < 50) ? FUNC_INSERT : FUNC_REMOVE;
            end else begin
               func = func_type'($urandom_range(3));
            end
            queue_command(func, (func == FUNC_INSERT) ? pick_key() : key_type'($urandom));
            made++;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (pending_items.size() == 0 && expected_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch("results still outstanding at end of run");
      end

      $display("covered %0d items, %0d results: %0d inserts, %0d removes, %0d clears",
               items_taken, results_seen, inserts_done, removes_done, clears_done);
      $display("refused full inserts %0d, empty removes %0d, order writes %0d, errors %0d",
               full_refusals, empty_removes, order_writes, error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/bhpq_pkg.sv
hw/rtl/binary_heap_priority_queue.sv
tb/binary_heap_priority_queue_test.sv
